// File: src/u8v_pkg.sv
`default_nettype none

package u8v_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] C_ASCII_MAX   = 8'h7F;
    localparam logic [7:0] C_CONT_LO     = 8'h80;
    localparam logic [7:0] C_CONT_HI     = 8'hBF;
    localparam logic [7:0] C_LEAD2_LO    = 8'hC2;
    localparam logic [7:0] C_LEAD2_HI    = 8'hDF;
    localparam logic [7:0] C_LEAD3_LO    = 8'hE0;
    localparam logic [7:0] C_LEAD3_HI    = 8'hEF;
    localparam logic [7:0] C_LEAD4_LO    = 8'hF0;
    localparam logic [7:0] C_LEAD4_HI    = 8'hF4;
    localparam logic [7:0] C_LEAD_E0     = 8'hE0;
    localparam logic [7:0] C_LEAD_ED     = 8'hED;
    localparam logic [7:0] C_LEAD_F0     = 8'hF0;
    localparam logic [7:0] C_LEAD_F4     = 8'hF4;
    localparam logic [7:0] C_E0_CONT_LO  = 8'hA0;
    localparam logic [7:0] C_ED_CONT_HI  = 8'h9F;
    localparam logic [7:0] C_F0_CONT_LO  = 8'h90;
    localparam logic [7:0] C_F4_CONT_HI  = 8'h8F;
    localparam logic [7:0] C_ESC_FIRST   = 8'hED;
    localparam logic [7:0] C_ESC_MID     = 8'hAC;
    localparam logic [7:0] C_ESC_LOW_TAG = 8'h80;

    localparam logic [2:0] C_LEN_NONE = 3'd0;
    localparam logic [2:0] C_LEN_2    = 3'd2;
    localparam logic [2:0] C_LEN_3    = 3'd3;
    localparam logic [2:0] C_LEN_4    = 3'd4;

    localparam logic [1:0] C_PH_FIRST = 2'd0;
    localparam logic [1:0] C_PH_MID   = 2'd1;
    localparam logic [1:0] C_PH_LAST  = 2'd2;

    // One command holds every symbol that one input item releases: a symbol is
    // a byte that is either passed through or escaped into three bytes.
    typedef struct packed {
        logic [3:0][7:0] sym_byte;
        logic [3:0]      sym_esc;
        logic [2:0]      sym_cnt;
        logic            last;
    } t_cmd;

endpackage

`default_nettype wire

// File: src/u8v_in_if.sv
`default_nettype none

interface u8v_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

`default_nettype wire

// File: src/u8v_out_if.sv
`default_nettype none

interface u8v_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       escaped;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output escaped, output run_last,
                    output stream_end, input ready);
    modport sink   (input valid, input out_byte, input escaped, input run_last,
                    input stream_end, output ready);
endinterface

`default_nettype wire

// File: src/utf8_validate_escape_invalid_core.sv
// Channel   Direction  Carries                                     Accepted when
// i_in_chan in         in_byte[7:0], is_last                       valid && ready
// o_out_chan out       out_byte[7:0], escaped, run_last, stream_end valid && ready
//
// The front classifies one byte per cycle while the queue has room; valid text
// leaves at one byte per cycle while the output is ready. An item releases one
// output byte per passed and three per escaped byte, 0 to 12 at the output port,
// the only serial resource. Commands pass the queue, then the output register.
// Reset is synchronous and clears pending state, the queue and the output register.
// Input ready drops only when the command queue is full; the output stalls freely.
`default_nettype none

module utf8_validate_escape_invalid_core
    import u8v_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    u8v_in_if.sink    i_in_chan,
    u8v_out_if.source o_out_chan
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic front_push;
    logic q_space;
    logic q_avail;
    logic back_pop;

    u8v_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_chan.valid),
        .i_byte  (i_in_chan.in_byte),
        .i_last  (i_in_chan.is_last),
        .i_space (q_space),
        .o_ready (i_in_chan.ready),
        .o_push  (front_push),
        .o_cmd   (front_cmd)
    );

    u8v_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_space (q_space),
        .o_avail (q_avail),
        .o_head  (head_cmd)
    );

    u8v_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_head  (head_cmd),
        .o_pop   (back_pop),
        .o_out   (o_out_chan)
    );

endmodule

`default_nettype wire

// File: src/u8v_front.sv
`default_nettype none

module u8v_front
    import u8v_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_space,
    output logic            o_ready,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic [7:0] r_pend [3];
    logic [1:0] r_cnt;
    logic [2:0] r_len;
    logic [1:0] n_cnt;
    logic [2:0] n_len;

    logic       accept;
    logic [2:0] f_len;
    logic       f_emit;
    logic       f_esc;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       ok;
    logic       complete;
    logic       pend_emit;
    logic       pend_esc;
    logic       b_emit;
    logic       b_esc;
    logic       wr_en;
    logic [1:0] wr_idx;
    logic [2:0] out_cnt;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    always_comb begin
        f_len = C_LEN_NONE;
        if (i_byte >= C_LEAD2_LO && i_byte <= C_LEAD2_HI) begin
            f_len = C_LEN_2;
        end else if (i_byte >= C_LEAD3_LO && i_byte <= C_LEAD3_HI) begin
            f_len = C_LEN_3;
        end else if (i_byte >= C_LEAD4_LO && i_byte <= C_LEAD4_HI) begin
            f_len = C_LEN_4;
        end
        f_emit = (i_byte <= C_ASCII_MAX) || (f_len == C_LEN_NONE) || i_last;
        f_esc  = (i_byte > C_ASCII_MAX) && f_emit;

        lo = C_CONT_LO;
        hi = C_CONT_HI;
        if (r_cnt == 2'd1) begin
            case (r_pend[0])
                C_LEAD_E0: lo = C_E0_CONT_LO;
                C_LEAD_ED: hi = C_ED_CONT_HI;
                C_LEAD_F0: lo = C_F0_CONT_LO;
                C_LEAD_F4: hi = C_F4_CONT_HI;
                default:   lo = C_CONT_LO;
            endcase
        end
        ok       = (i_byte >= lo) && (i_byte <= hi);
        complete = ok && (({1'b0, r_cnt} + 3'd1) == r_len);

        pend_emit = 1'b0;
        pend_esc  = 1'b0;
        b_emit    = 1'b0;
        b_esc     = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = r_cnt;
        n_cnt     = r_cnt;
        n_len     = r_len;

        if (r_cnt == 2'd0) begin
            b_emit = f_emit;
            b_esc  = f_esc;
            if (!f_emit) begin
                wr_en  = 1'b1;
                wr_idx = 2'd0;
                n_cnt  = 2'd1;
                n_len  = f_len;
            end
        end else if (complete) begin
            pend_emit = 1'b1;
            b_emit    = 1'b1;
            n_cnt     = 2'd0;
            n_len     = C_LEN_NONE;
        end else if (ok && i_last) begin
            pend_emit = 1'b1;
            pend_esc  = 1'b1;
            b_emit    = 1'b1;
            b_esc     = 1'b1;
            n_cnt     = 2'd0;
            n_len     = C_LEN_NONE;
        end else if (ok && r_cnt < 2'd3) begin
            wr_en = 1'b1;
            n_cnt = r_cnt + 2'd1;
        end else begin
            // The byte breaks the sequence: escape what is held, then restart on it.
            pend_emit = 1'b1;
            pend_esc  = 1'b1;
            b_emit    = f_emit;
            b_esc     = f_esc;
            n_cnt     = 2'd0;
            n_len     = C_LEN_NONE;
            if (!f_emit) begin
                wr_en  = 1'b1;
                wr_idx = 2'd0;
                n_cnt  = 2'd1;
                n_len  = f_len;
            end
        end

        out_cnt = (pend_emit ? {1'b0, r_cnt} : 3'd0) + {2'b00, b_emit};

        for (int k = 0; k < 3; k++) begin
            o_cmd.sym_byte[k] = (2'(k) < r_cnt) ? r_pend[k] : i_byte;
            o_cmd.sym_esc[k]  = (2'(k) < r_cnt) ? pend_esc : b_esc;
        end
        o_cmd.sym_byte[3] = i_byte;
        o_cmd.sym_esc[3]  = b_esc;
        o_cmd.sym_cnt     = out_cnt;
        o_cmd.last        = i_last;
    end

    assign o_push = accept && (out_cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_len <= C_LEN_NONE;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_pend[wr_idx] <= i_byte;
        end
    end

    a_len_tracks_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) == (r_len == C_LEN_NONE))
        else $error("pending count and sequence length disagree");

    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> ({1'b0, r_cnt} < r_len))
        else $error("pending sequence is longer than its lead allows");

    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (r_cnt == 2'd0))
        else $error("bytes left pending after the last item of a stream");

endmodule

`default_nettype wire

// File: src/u8v_queue.sv
`default_nettype none

module u8v_queue
    import u8v_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output logic      o_space,
    output logic      o_avail,
    output t_cmd      o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_fill;

    logic do_push;
    logic do_pop;

    assign o_space = (r_fill != FULL_CNT);
    assign o_avail = (r_fill != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/u8v_back.sv
`default_nettype none

module u8v_back
    import u8v_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_avail,
    input  t_cmd      i_head,
    output logic      o_pop,
    u8v_out_if.source o_out
);

    logic [1:0] r_sym;
    logic [1:0] r_ph;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_esc;
    logic       r_run_last;
    logic       r_end;

    logic [7:0] sb;
    logic       sesc;
    logic [7:0] cur_byte;
    logic       sym_done;
    logic       cmd_done;
    logic       load;

    always_comb begin
        sb   = i_head.sym_byte[r_sym];
        sesc = i_head.sym_esc[r_sym];
        case (r_ph)
            C_PH_FIRST: cur_byte = sesc ? C_ESC_FIRST : sb;
            C_PH_MID:   cur_byte = C_ESC_MID + {6'd0, sb[7:6]};
            default:    cur_byte = C_ESC_LOW_TAG | {2'b00, sb[5:0]};
        endcase
        sym_done = !sesc || (r_ph == C_PH_LAST);
        cmd_done = sym_done && (({1'b0, r_sym} + 3'd1) == i_head.sym_cnt);
    end

    assign load  = i_avail && (!r_valid || o_out.ready);
    assign o_pop = load && cmd_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym   <= 2'd0;
            r_ph    <= C_PH_FIRST;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                if (cmd_done) begin
                    r_sym <= 2'd0;
                    r_ph  <= C_PH_FIRST;
                end else if (sym_done) begin
                    r_sym <= r_sym + 2'd1;
                    r_ph  <= C_PH_FIRST;
                end else begin
                    r_ph <= r_ph + 2'd1;
                end
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= cur_byte;
            r_esc      <= sesc;
            r_run_last <= cmd_done;
            r_end      <= cmd_done && i_head.last;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.escaped    = r_esc;
    assign o_out.run_last   = r_run_last;
    assign o_out.stream_end = r_end;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_out.ready) |=> ($stable(r_sym) && $stable(r_ph)))
        else $error("expansion advanced while the output was stalled");

    a_phase_only_in_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph != C_PH_FIRST) |-> (i_avail && i_head.sym_esc[r_sym] && r_ph != 2'd3))
        else $error("escape phase set outside an escaped symbol");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_end) |-> r_run_last)
        else $error("stream end flagged on a byte that does not close its item");

endmodule

`default_nettype wire
